[hdl/lidar_reflector_clustering_unit_defines.svh]
// ----------------------------------------------------------------------------
// Lidar reflector clustering: assertion macros
// Shared checks, written against the local i_clk and i_rst_n.
// ----------------------------------------------------------------------------
`ifndef LIDAR_REFLECTOR_CLUSTERING_UNIT_DEFINES_SVH
`define LIDAR_REFLECTOR_CLUSTERING_UNIT_DEFINES_SVH

// same-cycle implication
`define LRC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hdl/lrc_pkg.sv]
// ----------------------------------------------------------------------------
// Lidar reflector clustering: package
// Item types, widths, register indices, codes and reset values.
// ----------------------------------------------------------------------------
package lrc_pkg;

    localparam int MAX_BEAMS = 2048;
    localparam int BEAM_W    = $clog2(MAX_BEAMS + 1);

    localparam int RANGE_W   = 16;
    localparam int INTEN_W   = 16;
    localparam int GAP_W     = 8;
    localparam int MINPT_W   = 12;
    localparam int ANGLE_W   = 24;
    localparam int STEP_W    = 16;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int COUNT_W   = 13;
    localparam int STATUS_W  = 2;
    localparam int RACC_W    = 28;
    localparam int BACC_W    = 24;
    localparam int DIV_W     = STEP_W + BACC_W;
    localparam int CMP_W     = (BEAM_W > GAP_W) ? BEAM_W : GAP_W;

    // register indices
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FIRST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP       = 3'd4;

    // register reset values
    localparam logic [INTEN_W-1:0]        THRESHOLD_RST = 16'd245;
    localparam logic [GAP_W-1:0]          GAP_RST       = 8'd5;
    localparam logic [MINPT_W-1:0]        MIN_FIRST_RST = 12'd10;
    localparam logic signed [ANGLE_W-1:0] START_RST     = -24'sd102944;
    localparam logic [STEP_W-1:0]         STEP_RST      = 16'd286;

    localparam logic [COUNT_W-1:0] SEEN_MAX     = 13'h1FFF;
    localparam logic [COUNT_W-1:0] THREE_CLUST  = 13'd3;

    localparam logic KIND_CLUSTER = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SMALL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_THREE = 2'd2;

    typedef struct packed {
        logic [RANGE_W-1:0] sample_range;
        logic [INTEN_W-1:0] sample_intensity;
        logic               scan_end;
    } t_in_item;

    typedef struct packed {
        logic                      item_kind;
        logic [RANGE_W-1:0]        mean_range;
        logic signed [ANGLE_W-1:0] mean_angle;
        logic [COUNT_W-1:0]        point_total;
        logic [STATUS_W-1:0]       scan_status;
        logic                      last_of_run;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic eval;
        logic div_start;
        logic emit_cluster;
        logic emit_summary;
    } t_dp_cmd;

    typedef struct packed {
        logic close_req;
        logic scan_end;
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage

[hdl/lrc_divider.sv]
// ----------------------------------------------------------------------------
// Lidar reflector clustering: serial divider
// Two restoring divide lanes sharing one divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`include "lidar_reflector_clustering_unit_defines.svh"

module lrc_divider
    import lrc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_W-1:0]   i_dividend_a,
    input  logic [DIV_W-1:0]   i_dividend_b,
    input  logic [COUNT_W-1:0] i_divisor,
    output logic [DIV_W-1:0]   o_quot_a,
    output logic [DIV_W-1:0]   o_quot_b,
    output logic               o_done
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]   r_dvd_a, n_dvd_a, r_dvd_b, n_dvd_b;
    logic [COUNT_W-1:0] r_rem_a, n_rem_a, r_rem_b, n_rem_b;
    logic [COUNT_W-1:0] r_div;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_done;

    // one restoring step: returns {remainder, dividend/quotient shift}
    function automatic logic [COUNT_W+DIV_W-1:0] div_step(
        input logic [COUNT_W-1:0] rem,
        input logic [DIV_W-1:0]   dvd,
        input logic [COUNT_W-1:0] dvs
    );
        logic [COUNT_W:0]   shifted;
        logic [COUNT_W+1:0] diff;
        logic               ge;
        shifted = {rem, dvd[DIV_W-1]};
        diff    = {1'b0, shifted} - {2'b00, dvs};
        ge      = !diff[COUNT_W+1];
        if (ge) begin
            div_step = {diff[COUNT_W-1:0], dvd[DIV_W-2:0], 1'b1};
        end else begin
            div_step = {shifted[COUNT_W-1:0], dvd[DIV_W-2:0], 1'b0};
        end
    endfunction

    always_comb begin
        {n_rem_a, n_dvd_a} = div_step(r_rem_a, r_dvd_a, r_div);
        {n_rem_b, n_dvd_b} = div_step(r_rem_b, r_dvd_b, r_div);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CNT_W'(DIV_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd_a <= i_dividend_a;
            r_dvd_b <= i_dividend_b;
            r_rem_a <= '0;
            r_rem_b <= '0;
            r_div   <= i_divisor;
        end else if (r_cnt != '0) begin
            r_dvd_a <= n_dvd_a;
            r_dvd_b <= n_dvd_b;
            r_rem_a <= n_rem_a;
            r_rem_b <= n_rem_b;
        end
    end

    assign o_quot_a = r_dvd_a;
    assign o_quot_b = r_dvd_b;
    assign o_done   = r_done;

    `LRC_ASSERT_NOW(a_no_restart, r_cnt != '0, !i_start, "divider restarted mid-run")

endmodule

[hdl/lrc_datapath.sv]
// ----------------------------------------------------------------------------
// Lidar reflector clustering: datapath
// Config registers, cluster accumulators, centroid maths and output register.
// ----------------------------------------------------------------------------
`include "lidar_reflector_clustering_unit_defines.svh"

module lrc_datapath
    import lrc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_in_item             i_in_item,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item
);

    localparam int SUM_W = DIV_W + 2;

    // configuration
    logic [INTEN_W-1:0]        r_thr;
    logic [GAP_W-1:0]          r_gap;
    logic [MINPT_W-1:0]        r_min_first;
    logic signed [ANGLE_W-1:0] r_start;
    logic [STEP_W-1:0]         r_step;

    // captured item
    t_in_item r_item;

    // scan state
    logic [BEAM_W-1:0]  r_beam, r_idx, r_first;
    logic               r_open;
    logic [RACC_W-1:0]  r_racc;
    logic [BACC_W-1:0]  r_bacc;
    logic [COUNT_W-1:0] r_hits, r_seen, r_first_size;

    logic               r_out_valid;
    t_out_item          r_out;

    logic               beam_ok, hit, out_free;
    logic [BEAM_W-1:0]  beam_diff;
    logic [COUNT_W-1:0] divisor;
    logic [DIV_W-1:0]   quot_a, quot_b, prod;
    logic               div_done;
    logic signed [SUM_W-1:0] angle_sum;
    logic signed [ANGLE_W-1:0] angle_sat;
    logic [STATUS_W-1:0] status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= THRESHOLD_RST;
            r_gap       <= GAP_RST;
            r_min_first <= MIN_FIRST_RST;
            r_start     <= START_RST;
            r_step      <= STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_thr       <= i_cfg_data[INTEN_W-1:0];
                CFG_GAP:       r_gap       <= i_cfg_data[GAP_W-1:0];
                CFG_MIN_FIRST: r_min_first <= i_cfg_data[MINPT_W-1:0];
                CFG_START:     r_start     <= i_cfg_data[ANGLE_W-1:0];
                CFG_STEP:      r_step      <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_item;
        end
    end

    assign beam_ok   = r_beam < BEAM_W'(MAX_BEAMS);
    assign hit       = beam_ok && (r_item.sample_intensity >= r_thr);
    assign beam_diff = r_idx - r_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beam       <= '0;
            r_idx        <= '0;
            r_first      <= '0;
            r_open       <= 1'b0;
            r_racc       <= '0;
            r_bacc       <= '0;
            r_hits       <= '0;
            r_seen       <= '0;
            r_first_size <= '0;
        end else if (i_cmd.eval) begin
            r_idx <= r_beam;
            if (beam_ok) begin
                r_beam <= r_beam + 1'b1;
            end
            if (hit) begin
                if (!r_open) begin
                    r_open  <= 1'b1;
                    r_first <= r_beam;
                    r_racc  <= RACC_W'(r_item.sample_range);
                    r_bacc  <= BACC_W'(r_beam);
                    r_hits  <= COUNT_W'(1);
                end else begin
                    r_racc  <= r_racc + RACC_W'(r_item.sample_range);
                    r_bacc  <= r_bacc + BACC_W'(r_beam);
                    r_hits  <= r_hits + 1'b1;
                end
            end
        end else if (i_cmd.emit_cluster) begin
            if (r_seen == '0) begin
                r_first_size <= r_hits;
            end
            if (r_seen != SEEN_MAX) begin
                r_seen <= r_seen + 1'b1;
            end
            r_open <= 1'b0;
            r_racc <= '0;
            r_bacc <= '0;
            r_hits <= '0;
        end else if (i_cmd.emit_summary) begin
            // every scan starts empty
            r_beam       <= '0;
            r_first      <= '0;
            r_open       <= 1'b0;
            r_racc       <= '0;
            r_bacc       <= '0;
            r_hits       <= '0;
            r_seen       <= '0;
            r_first_size <= '0;
        end
    end

    assign divisor = (r_hits == '0) ? COUNT_W'(1) : r_hits;
    assign prod    = DIV_W'(r_step * r_bacc);

    lrc_divider u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_cmd.div_start),
        .i_dividend_a (DIV_W'(r_racc)),
        .i_dividend_b (prod),
        .i_divisor    (divisor),
        .o_quot_a     (quot_a),
        .o_quot_b     (quot_b),
        .o_done       (div_done)
    );

    // start angle plus offset, clipped to the 24-bit signed range
    always_comb begin
        angle_sum = SUM_W'(r_start) + $signed({2'b00, quot_b});
        if (angle_sum[SUM_W-1:ANGLE_W-1] == '0 || angle_sum[SUM_W-1:ANGLE_W-1] == '1) begin
            angle_sat = angle_sum[ANGLE_W-1:0];
        end else if (angle_sum[SUM_W-1]) begin
            angle_sat = {1'b1, {(ANGLE_W-1){1'b0}}};
        end else begin
            angle_sat = {1'b0, {(ANGLE_W-1){1'b1}}};
        end
    end

    always_comb begin
        if (r_first_size < COUNT_W'(r_min_first)) begin
            status = ST_SMALL;
        end else if (r_seen != THREE_CLUST) begin
            status = ST_NOT_THREE;
        end else begin
            status = ST_OK;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_cluster || i_cmd.emit_summary) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_cluster) begin
            r_out.item_kind   <= KIND_CLUSTER;
            r_out.mean_range  <= quot_a[RANGE_W-1:0];
            r_out.mean_angle  <= angle_sat;
            r_out.point_total <= r_hits;
            r_out.scan_status <= ST_OK;
            r_out.last_of_run <= !r_item.scan_end;
        end else if (i_cmd.emit_summary) begin
            r_out.item_kind   <= KIND_SUMMARY;
            r_out.mean_range  <= '0;
            r_out.mean_angle  <= '0;
            r_out.point_total <= r_seen;
            r_out.scan_status <= status;
            r_out.last_of_run <= 1'b1;
        end
    end

    always_comb begin
        o_stat.close_req = r_open &&
            (r_item.scan_end || (CMP_W'(beam_diff) >= CMP_W'(r_gap)));
        o_stat.scan_end  = r_item.scan_end;
        o_stat.div_done  = div_done;
        o_stat.out_free  = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `LRC_ASSERT_NOW(a_no_overwrite, r_out_valid && i_out_stall, !(i_cmd.emit_cluster || i_cmd.emit_summary), "held item overwritten")
    `LRC_ASSERT_NOW(a_open_has_hits, r_open, r_hits != '0, "open cluster without hits")
    `LRC_ASSERT_NOW(a_emit_open, i_cmd.emit_cluster, r_open, "centroid from closed cluster")

endmodule

[hdl/lrc_ctrl.sv]
// ----------------------------------------------------------------------------
// Lidar reflector clustering: controller
// Sequences capture, update, divide and the two result kinds per item.
// ----------------------------------------------------------------------------
`include "lidar_reflector_clustering_unit_defines.svh"

module lrc_ctrl
    import lrc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EVAL   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_EMIT_C = 3'd5;
    localparam logic [2:0] S_EMIT_S = 3'd6;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_stat.close_req) begin
                    n_state = S_MUL;
                end else if (i_stat.scan_end) begin
                    n_state = S_EMIT_S;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_EMIT_C;
                end
            end
            S_EMIT_C: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_cluster = 1'b1;
                    n_state = i_stat.scan_end ? S_EMIT_S : S_IDLE;
                end
            end
            S_EMIT_S: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_summary = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

[hdl/lidar_reflector_clustering_unit.sv]
// ----------------------------------------------------------------------------
// Lidar reflector clustering unit
// Groups bright lidar beams into reflector clusters and reports centroids.
// ----------------------------------------------------------------------------
// Input channel: one beam item (range, intensity, scan_end) per handshake on
// i_in_valid / o_in_stall. Output channel: o_out_valid / i_out_stall carries
// cluster centroids and an end-of-scan summary; last_of_run marks the final
// result caused by a beam.
// Config: write i_cfg_data to register i_cfg_index with i_cfg_we, only while
// the block is idle. Indices 0..4: threshold, gap, min first points, start
// angle, angle step; other indices are ignored.
// Sequence: a beam that closes no cluster and ends no scan passes through the
// capture, update and decide steps before the next accept. One that closes a
// cluster then starts the 40-step bit-serial divider, whose mean range and
// mean angle lanes share one divisor. A summary adds its own emit state. A
// result shows on the output from the cycle after the one that loads it.
// One beam is worked on at a time: o_in_stall stays high from the accept until
// the beam's last result is loaded. A finished result sits in the output
// register, and loading the next one waits while the receiver stalls it.
// Reset (synchronous, active low) restores the register defaults, empties the
// scan state and drops o_out_valid.
// ----------------------------------------------------------------------------
module lidar_reflector_clustering_unit
    import lrc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    lrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lrc_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

[test/tb_lidar_reflector_clustering_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lidar reflector clustering unit: testbench
// Drives beam items with random gaps and output stalls, predicts every cluster
// centroid and scan summary in step with each accepted item, and compares each
// result field by field. Directed scans cover threshold edges, register
// extremes and gap closing; random phases use fresh registers.
// ----------------------------------------------------------------------------
module tb_lidar_reflector_clustering_unit;
    import lrc_pkg::*;

    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam int          SETTLE_CYCLES = 60;
    localparam int          IDLE_PERCENT  = 22;
    localparam int          RANDOM_PHASES = 5;
    localparam int          PHASE_BEAMS   = 90;
    localparam int          SPARE_INDEX   = CFG_STEP + 1;
    localparam int          LAST_INDEX    = 2 ** CFG_IDX_W - 1;
    localparam longint      ANGLE_TOP     = (longint'(1) <<< (ANGLE_W - 1)) - 1;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_item   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_item;

    lidar_reflector_clustering_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // register copies
    logic [INTEN_W-1:0]        thr_q       = THRESHOLD_RST;
    logic [GAP_W-1:0]          gap_q       = GAP_RST;
    logic [MINPT_W-1:0]        min_first_q = MIN_FIRST_RST;
    logic signed [ANGLE_W-1:0] start_q     = START_RST;
    logic [STEP_W-1:0]         step_q      = STEP_RST;

    // scan state
    logic [BEAM_W-1:0]  beam_no        = '0;
    logic               cluster_open   = 1'b0;
    logic [BEAM_W-1:0]  first_beam     = '0;
    logic [RACC_W-1:0]  range_sum      = '0;
    logic [BACC_W-1:0]  index_sum      = '0;
    logic [COUNT_W-1:0] hit_total      = '0;
    logic [COUNT_W-1:0] clusters_found = '0;
    logic [COUNT_W-1:0] first_size     = '0;

    t_out_item pending_reports[$];
    t_in_item  scan_beams[$];
    int        mismatch_count = 0;
    int        cycle_count    = 0;
    int        beams_sent     = 0;
    bit        no_idle        = 1'b0;

    function automatic void clear_scan_state();
        beam_no        = '0;
        cluster_open   = 1'b0;
        first_beam     = '0;
        range_sum      = '0;
        index_sum      = '0;
        hit_total      = '0;
        clusters_found = '0;
        first_size     = '0;
    endfunction

    // Works out the centroid and summary that one accepted beam causes.
    function automatic void advance_clusterer(t_in_item b);
        logic [BEAM_W-1:0] idx;
        bit                in_scan;
        longint            angle;
        t_out_item         r;
        idx     = beam_no;
        in_scan = idx < MAX_BEAMS;
        if (in_scan && b.sample_intensity >= thr_q) begin
            if (!cluster_open) begin
                cluster_open = 1'b1;
                first_beam   = idx;
                range_sum    = '0;
                index_sum    = '0;
                hit_total    = '0;
            end
            range_sum += b.sample_range;
            index_sum += idx;
            hit_total++;
        end
        if (cluster_open && (b.scan_end || idx - first_beam >= gap_q)) begin
            // offset is never negative, so only the top can saturate
            angle = longint'(start_q)
                  + (longint'(step_q) * longint'(index_sum)) / longint'(hit_total);
            if (angle > ANGLE_TOP) angle = ANGLE_TOP;
            r               = '0;
            r.item_kind     = KIND_CLUSTER;
            r.mean_range    = RANGE_W'(range_sum / hit_total);
            r.mean_angle    = ANGLE_W'(angle);
            r.point_total   = hit_total;
            r.scan_status   = ST_OK;
            r.last_of_run   = !b.scan_end;
            pending_reports.insert(pending_reports.size(), r);
            if (clusters_found == '0) first_size = hit_total;
            if (clusters_found != SEEN_MAX) clusters_found++;
            cluster_open = 1'b0;
            range_sum    = '0;
            index_sum    = '0;
            hit_total    = '0;
        end
        if (in_scan) beam_no = idx + 1'b1;
        if (b.scan_end) begin
            r             = '0;
            r.item_kind   = KIND_SUMMARY;
            r.point_total = clusters_found;
            if (first_size < min_first_q) r.scan_status = ST_SMALL;
            else if (clusters_found != THREE_CLUST) r.scan_status = ST_NOT_THREE;
            else r.scan_status = ST_OK;
            r.last_of_run = 1'b1;
            pending_reports.insert(pending_reports.size(), r);
            clear_scan_state();
        end
    endfunction

    task automatic flag_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic signed [63:0] got,
                               logic signed [63:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    always @(posedge i_clk) begin : check_reports
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_reports.size() == 0) begin
                flag_mismatch($sformatf("unexpected item, kind %0d total %0d",
                                        o_out_item.item_kind, o_out_item.point_total));
            end else begin
                want = pending_reports.pop_front();
                check_field("item_kind", o_out_item.item_kind, want.item_kind);
                check_field("mean_range", o_out_item.mean_range, want.mean_range);
                check_field("mean_angle", o_out_item.mean_angle, want.mean_angle);
                check_field("point_total", o_out_item.point_total, want.point_total);
                check_field("scan_status", o_out_item.scan_status, want.scan_status);
                check_field("last_of_run", o_out_item.last_of_run, want.last_of_run);
            end
        end
    end

    always @(posedge i_clk)
        i_out_stall <= !no_idle && ($urandom_range(99) < IDLE_PERCENT);

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_beam(logic [RANGE_W-1:0] rng, logic [INTEN_W-1:0] inten,
                             bit last);
        t_in_item b;
        b.sample_range     = rng;
        b.sample_intensity = inten;
        b.scan_end         = last;
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= b;
        do @(posedge i_clk); while (o_in_stall);
        advance_clusterer(b);
        beams_sent++;
    endtask

    // Waits for every pending result, then lets the block settle.
    task automatic drain_reports();
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Block must be idle here.
    task automatic apply_config(logic [INTEN_W-1:0] thr, logic [GAP_W-1:0] gap,
                                logic [MINPT_W-1:0] min_first,
                                logic signed [ANGLE_W-1:0] start,
                                logic [STEP_W-1:0] step);
        cfg_write(CFG_THRESHOLD, CFG_W'(thr));
        cfg_write(CFG_GAP, CFG_W'(gap));
        cfg_write(CFG_MIN_FIRST, CFG_W'(min_first));
        cfg_write(CFG_START, CFG_W'(start));
        cfg_write(CFG_STEP, CFG_W'(step));
        // unused index: must leave every register alone
        cfg_write(CFG_IDX_W'($urandom_range(LAST_INDEX, SPARE_INDEX)), CFG_W'($urandom));
        i_cfg_we    <= 1'b0;
        thr_q       = thr;
        gap_q       = gap;
        min_first_q = min_first;
        start_q     = start;
        step_q      = step;
    endtask

    function automatic logic [INTEN_W-1:0] pick_intensity(bit hit);
        if (hit || thr_q == '0) return INTEN_W'($urandom_range(65535, thr_q));
        return INTEN_W'($urandom_range(thr_q - 1, 0));
    endfunction

    function automatic void queue_beam(bit hit);
        t_in_item b;
        b.sample_range     = RANGE_W'($urandom);
        b.sample_intensity = pick_intensity(hit);
        b.scan_end         = 1'b0;
        scan_beams.insert(scan_beams.size(), b);
    endfunction

    task automatic send_scan();
        t_in_item b;
        if (scan_beams.size() == 0) queue_beam($urandom_range(1));
        scan_beams[scan_beams.size() - 1].scan_end = 1'b1;
        while (scan_beams.size() != 0) begin
            b = scan_beams.pop_front();
            send_beam(b.sample_range, b.sample_intensity, b.scan_end);
        end
    endtask

    // Bright runs with enough dark beams after each to close it; mostly three.
    task automatic send_reflector_scan();
        int reflectors;
        int run;
        int pad;
        reflectors = ($urandom_range(9) < 6) ? 3 : $urandom_range(5, 1);
        for (int k = 0; k < reflectors; k++) begin
            repeat ($urandom_range(2)) queue_beam(1'b0);
            run = $urandom_range((gap_q < 5) ? gap_q + 1 : 6, 1);
            repeat (run) queue_beam(1'b1);
            pad = gap_q - run + 1 + $urandom_range(2);
            repeat (pad) queue_beam(1'b0);
        end
        send_scan();
    endtask

    task automatic send_noise_scan();
        repeat ($urandom_range(30, 1)) queue_beam($urandom_range(1));
        send_scan();
    endtask

    // Reset registers: threshold edges, field extremes, empty scan.
    task automatic test_threshold_edges();
        send_beam(16'd0, 16'd244, 1'b0);
        send_beam(16'd65535, 16'd245, 1'b0);
        send_beam(16'd0, 16'd65535, 1'b0);
        send_beam(16'd1234, 16'd0, 1'b0);
        send_beam(16'd500, 16'd300, 1'b1);
        send_beam(16'd7, 16'd0, 1'b1);
        drain_reports();
    endtask

    task automatic test_config_extremes();
        // every beam a one-point cluster, flat angle, min_first zero
        apply_config(16'd0, 8'd0, 12'd0, -24'sd8388608, 16'd0);
        send_beam(16'd65535, 16'd0, 1'b0);
        send_beam(16'd1, 16'd65535, 1'b0);
        send_beam(16'd100, 16'd5, 1'b1);
        send_beam(16'd42, 16'd9, 1'b1);
        drain_reports();
        // top of every register, angle saturates
        apply_config(16'd65535, 8'd255, 12'd4095, 24'sd8388607, 16'd65535);
        send_beam(16'd100, 16'd65534, 1'b0);
        send_beam(16'd200, 16'd65535, 1'b0);
        send_beam(16'd300, 16'd65535, 1'b0);
        send_beam(16'd0, 16'd0, 1'b1);
        drain_reports();
    endtask

    task automatic test_gap_closing();
        apply_config(16'd1000, 8'd2, 12'd0, 24'sd0, 16'd1000);
        send_beam(16'd50, 16'd999, 1'b1);
        send_beam(16'd10, 16'd1000, 1'b0);
        send_beam(16'd20, 16'd2000, 1'b0);
        send_beam(16'd30, 16'd3000, 1'b0);
        send_beam(16'd40, 16'd4000, 1'b0);
        send_beam(16'd55, 16'd10, 1'b0);
        send_beam(16'd60, 16'd5000, 1'b1);
        drain_reports();
    endtask

    task automatic test_random_scans();
        int stop_at;
        bit wide_gap;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wide_gap = (phase == RANDOM_PHASES - 1);
            apply_config(INTEN_W'($urandom_range(1) ? $urandom_range(65535)
                                                    : $urandom_range(2000)),
                         GAP_W'(wide_gap ? $urandom_range(255, 100) : $urandom_range(4)),
                         MINPT_W'(wide_gap ? $urandom_range(4095) : $urandom_range(4)),
                         ANGLE_W'($urandom), STEP_W'($urandom));
            no_idle = (phase == 2);
            stop_at = beams_sent + PHASE_BEAMS;
            while (beams_sent < stop_at) begin
                if (!wide_gap && $urandom_range(9) < 7) send_reflector_scan();
                else send_noise_scan();
            end
            drain_reports();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_threshold_edges();
        test_config_extremes();
        test_gap_closing();
        test_random_scans();
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
